### design/mlpq_pkg.sv
// mlpq_pkg: shared types and codes for the multilevel priority ready queue
// used by the controller, the datapath and the top level; depends on nothing

package mlpq_pkg;

  localparam int ID_W     = 6;
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FETCH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture the request fields
    logic push;        // append to the requested level
    logic pop;         // remove the head of the most urgent level
    logic post_eval;   // result known without a memory read
    logic post_fetch;  // result comes from the memory read
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_deq;
    logic can_push;
    logic can_pop;
  } dp_status_t;

endpackage

### design/mlpq_ram.sv
// mlpq_ram: generic simple dual-port ram, one write and one registered read port
// no package dependencies

module mlpq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mlpq_ctrl.sv
// mlpq_ctrl: request sequencer for the ready queue
// depends on mlpq_pkg for the state type and command/status structs

module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  ctrl_cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl_cmd   = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_cmd.latch = 1'b1;
          state_next     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (dp_status.is_deq && dp_status.can_pop) begin
          ctrl_cmd.pop = 1'b1;
          state_next   = S_FETCH;
        end else begin
          ctrl_cmd.push      = !dp_status.is_deq && dp_status.can_push;
          ctrl_cmd.post_eval = 1'b1;
          state_next         = S_IDLE;
        end
      end
      S_FETCH: begin
        ctrl_cmd.post_fetch = 1'b1;
        state_next          = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/mlpq_dp.sv
// mlpq_dp: per-level head, tail and count registers, entry ram and result registers
// depends on mlpq_pkg and mlpq_ram

module mlpq_dp
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           ctrl_cmd,
  output dp_status_t          dp_status,
  input  logic                command,
  input  logic [PRIO_W-1:0]   priority_level,
  input  logic [ID_W-1:0]     process_id,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     served_id,
  output logic [PRIO_W-1:0]   served_level
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(ENTRIES);

  logic              cmd_q;
  logic [PRIO_W-1:0] prio_q;
  logic [ID_W-1:0]   pid_q;

  logic [PTR_W-1:0] heads  [NUM_LEVELS];
  logic [PTR_W-1:0] tails  [NUM_LEVELS];
  logic [CNT_W-1:0] counts [NUM_LEVELS];

  logic [LVL_W-1:0]  enq_lvl;
  logic              in_range;
  logic              found;
  logic [LVL_W-1:0]  sel;
  logic [LVL_W-1:0]  pop_lvl;
  logic [PTR_W-1:0]  tail_cur;
  logic [PTR_W-1:0]  head_cur;
  logic [PTR_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  head_inc;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ID_W-1:0]   rdata;

  always_ff @(posedge clk) begin
    if (ctrl_cmd.latch) begin
      cmd_q  <= command;
      prio_q <= priority_level;
      pid_q  <= process_id;
    end
  end

  assign in_range = 32'(prio_q) < NUM_LEVELS;
  assign enq_lvl  = LVL_W'(prio_q);

  // lowest-numbered level holding anything wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        found = 1'b1;
        sel   = LVL_W'(i);
      end
    end
  end

  assign tail_cur = tails[enq_lvl];
  assign head_cur = heads[sel];
  assign tail_inc = (tail_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + PTR_W'(1);
  assign head_inc = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PTR_W'(1);

  assign waddr = ADDR_W'(enq_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_cur);
  assign raddr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_cur);

  assign dp_status.is_deq   = (cmd_q == CMD_DEQ);
  assign dp_status.can_push = in_range && (counts[enq_lvl] != CNT_W'(QUEUE_DEPTH));
  assign dp_status.can_pop  = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else if (ctrl_cmd.push) begin
      tails[enq_lvl]  <= tail_inc;
      counts[enq_lvl] <= counts[enq_lvl] + CNT_W'(1);
    end else if (ctrl_cmd.pop) begin
      heads[sel]  <= head_inc;
      counts[sel] <= counts[sel] - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.pop) begin
      pop_lvl <= sel;
    end
  end

  mlpq_ram #(
    .WIDTH (ID_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl_cmd.push),
    .waddr (waddr),
    .wdata (pid_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_cmd.post_eval || ctrl_cmd.post_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.post_fetch) begin
      status       <= ST_OK;
      served_id    <= rdata;
      served_level <= PRIO_W'(pop_lvl);
    end else if (ctrl_cmd.post_eval) begin
      if (dp_status.is_deq) begin
        status <= ST_EMPTY;
      end else if (dp_status.can_push) begin
        status <= ST_OK;
      end else begin
        status <= ST_FULL;
      end
      served_id    <= '0;
      served_level <= '0;
    end
  end

endmodule

### design/multilevel_priority_ready_queue.sv
// multilevel_priority_ready_queue: top level joining the sequencer and the datapath
// depends on mlpq_pkg, mlpq_ctrl, mlpq_dp (and through it mlpq_ram)

// A request is taken on a rising edge with start high and busy low. An enqueue,
// a refused enqueue (full or level out of range) and a dequeue of an empty queue
// pass through S_EVAL only before the next request can be taken; a successful
// dequeue also passes through S_FETCH for the registered read of the entry ram. The result
// appears on status, served_id and served_level for exactly one cycle with done
// high, in the cycle busy drops, and cannot be held off by the receiver. All
// levels come up empty at reset with no clearing pass; the entry ram needs no
// initialisation because only written slots are ever read.

module multilevel_priority_ready_queue
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  logic [PRIO_W-1:0]   priority_level,
  input  logic [ID_W-1:0]     process_id,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     served_id,
  output logic [PRIO_W-1:0]   served_level
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  mlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  mlpq_dp #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl_cmd       (ctrl_cmd),
    .dp_status      (dp_status),
    .command        (command),
    .priority_level (priority_level),
    .process_id     (process_id),
    .done           (done),
    .status         (status),
    .served_id      (served_id),
    .served_level   (served_level)
  );

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block did not go busy");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("unknown status code on result");

  a_failed_fields_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> served_id == '0 && served_level == '0)
    else $error("served fields not cleared on a failed request");

endmodule
